>>> rtl/tmeu_pkg.sv
// Package for the tape machine execute unit: instruction codes, FSM states,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package tmeu_pkg;

    typedef enum logic [3:0] {
        K_ADD      = 4'd0,
        K_SET      = 4'd1,
        K_MOVE     = 4'd2,
        K_JZ       = 4'd3,
        K_JNZ      = 4'd4,
        K_PUT      = 4'd5,
        K_READ     = 4'd6,
        K_CLEAR    = 4'd7,
        K_MULCOPY  = 4'd8,
        K_SCANR    = 4'd9,
        K_SCANL    = 4'd10,
        K_END      = 4'd11
    } t_kind;

    localparam logic [1:0] EOF_KEEP = 2'd0;
    localparam logic [1:0] EOF_ZERO = 2'd1;
    localparam logic [1:0] EOF_FF   = 2'd2;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD_PTR,
        S_RD_ADDR,
        S_WAIT_A,
        S_RD_DST,
        S_WAIT_D,
        S_WRITE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OUT
    } t_state;

    // Memory address select
    typedef enum logic [2:0] {
        A_CLR,
        A_PTR,
        A_ADDR,
        A_DST,
        A_SCAN
    } t_asel;

    typedef struct packed {
        logic  clr_step;
        logic  load;
        t_asel asel;
        logic  mem_we;
        logic  cap_src;
        logic  scan_init;
        logic  scan_step;
        logic  finish;
        logic  fault_set;
        logic  ptr_move;
        logic  ptr_scan;
    } t_cmd;

    typedef struct packed {
        logic  clr_done;
        t_kind kind;
        logic  addr_ok;
        logic  dst_ok;
        logic  move_ok;
        logic  rd_zero;
        logic  scan_last;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/tmeu_if.sv
// Valid/ready stream interfaces for instruction words, result words and config.
// Depends on nothing.
`default_nettype none
interface tmeu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic signed [31:0] amount;
    logic signed [15:0] factor;
    logic signed [15:0] cell_offset;
    logic [7:0]         in_byte;
    logic               in_eof;
    modport source(output valid, kind, amount, factor, cell_offset, in_byte, in_eof,
                   input ready);
    modport sink(input valid, kind, amount, factor, cell_offset, in_byte, in_eof,
                 output ready);
endinterface

interface tmeu_out_if;
    logic               valid;
    logic               ready;
    logic               out_valid;
    logic [7:0]         out_byte;
    logic [30:0]        out_count;
    logic signed [31:0] pc_delta;
    logic [14:0]        pointer_now;
    logic               done_res;
    logic               fault;
    modport source(output valid, out_valid, out_byte, out_count, pc_delta, pointer_now,
                   done_res, fault, input ready);
    modport sink(input valid, out_valid, out_byte, out_count, pc_delta, pointer_now,
                 done_res, fault, output ready);
endinterface

interface tmeu_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] eof_mode;
    modport source(output valid, eof_mode, input ready);
    modport sink(input valid, eof_mode, output ready);
endinterface
`default_nettype wire

>>> rtl/tmeu_ram.sv
// Generic single-port RAM with registered read data. No dependencies.
`default_nettype none
module tmeu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/tmeu_ctrl.sv
// Controller FSM of the tape machine execute unit.
// Depends on tmeu_pkg.
`default_nettype none
module tmeu_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire tmeu_pkg::t_sts i_sts,
    output tmeu_pkg::t_cmd      o_cmd
);
    import tmeu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.asel  = A_ADDR;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.asel     = A_CLR;
                o_cmd.mem_we   = 1'b1;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD_PTR;
                end
            end
            S_RD_PTR: begin
                o_cmd.asel = A_PTR;
                case (i_sts.kind)
                    K_ADD, K_SET, K_READ, K_CLEAR, K_PUT, K_MULCOPY: begin
                        o_cmd.asel = A_ADDR;
                        if (!i_sts.addr_ok ||
                            (i_sts.kind == K_MULCOPY && !i_sts.dst_ok)) begin
                            o_cmd.fault_set = 1'b1;
                            n_state         = S_OUT;
                        end else begin
                            n_state = S_WAIT_A;
                        end
                    end
                    K_MOVE: begin
                        if (i_sts.move_ok) o_cmd.ptr_move = 1'b1;
                        else               o_cmd.fault_set = 1'b1;
                        n_state = S_OUT;
                    end
                    K_JZ, K_JNZ: n_state = S_RD_ADDR;
                    K_SCANR, K_SCANL: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN_RD;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_RD_ADDR: begin
                o_cmd.asel = A_PTR;
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_WAIT_A: begin
                o_cmd.asel    = A_ADDR;
                o_cmd.cap_src = 1'b1;
                if (i_sts.kind == K_MULCOPY) begin
                    n_state = S_RD_DST;
                end else begin
                    o_cmd.finish = 1'b1;
                    o_cmd.mem_we = (i_sts.kind != K_PUT);
                    n_state      = S_OUT;
                end
            end
            S_RD_DST: begin
                o_cmd.asel = A_DST;
                n_state    = S_WAIT_D;
            end
            S_WAIT_D: begin
                o_cmd.asel   = A_DST;
                o_cmd.mem_we = 1'b1;
                n_state      = S_OUT;
            end
            S_SCAN_RD: begin
                o_cmd.asel = A_SCAN;
                n_state    = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.asel = A_SCAN;
                if (i_sts.rd_zero) begin
                    o_cmd.ptr_scan = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.scan_last) begin
                    o_cmd.fault_set = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while result pending");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_RD_PTR))
        else $error("load outside idle");
endmodule
`default_nettype wire

>>> rtl/tmeu_dp.sv
// Datapath: tape RAM, pointer, operand registers, address checks and result.
// Depends on tmeu_pkg and tmeu_ram.
`default_nettype none
module tmeu_dp #(
    parameter int TAPE_DEPTH = 32768
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tmeu_pkg::t_cmd     i_cmd,
    output tmeu_pkg::t_sts          o_sts,
    input  wire logic [3:0]         i_kind,
    input  wire logic signed [31:0] i_amount,
    input  wire logic signed [15:0] i_factor,
    input  wire logic signed [15:0] i_cell_offset,
    input  wire logic [7:0]         i_in_byte,
    input  wire logic               i_in_eof,
    input  wire logic [1:0]         i_eof_mode,
    output logic                    o_out_valid,
    output logic [7:0]              o_out_byte,
    output logic [30:0]             o_out_count,
    output logic signed [31:0]      o_pc_delta,
    output logic [14:0]             o_pointer_now,
    output logic                    o_done_res,
    output logic                    o_fault
);
    import tmeu_pkg::*;

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam logic signed [34:0] DEPTH_S = 35'(TAPE_DEPTH);

    logic [3:0]         r_kind;
    logic signed [31:0] r_amount;
    logic [15:0]        r_factor;
    logic signed [15:0] r_offs;
    logic [7:0]         r_in_byte;
    logic               r_in_eof;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_scan;
    logic [7:0]         r_src;
    logic               r_fault;
    logic               r_jtaken;
    logic               r_put;
    logic [7:0]         r_obyte;

    logic signed [34:0] s_addr, s_dst, s_move, s_scan_nx;
    logic [31:0]        s_step;
    logic [7:0]         s_rdata, s_wdata, s_prod;
    logic [AW-1:0]      s_ram_addr;
    logic [23:0]        s_mul;

    assign s_addr = $signed({1'b0, 34'(r_ptr)}) + 35'(r_offs);
    assign s_dst  = s_addr + 35'(r_amount);
    assign s_move = $signed({1'b0, 34'(r_ptr)}) + 35'(r_amount);
    assign s_step = r_amount;
    assign s_scan_nx = (r_kind == K_SCANR)
        ? $signed({1'b0, 34'(r_scan)}) + $signed({3'b0, s_step})
        : $signed({1'b0, 34'(r_scan)}) - $signed({3'b0, s_step});

    assign s_mul  = 24'(r_src) * 24'(r_factor);
    assign s_prod = s_mul[7:0];

    always_comb begin
        case (i_cmd.asel)
            A_CLR:   s_ram_addr = r_clr;
            A_PTR:   s_ram_addr = r_ptr;
            A_DST:   s_ram_addr = s_dst[AW-1:0];
            A_SCAN:  s_ram_addr = r_scan;
            default: s_ram_addr = s_addr[AW-1:0];
        endcase
    end

    always_comb begin
        s_wdata = s_rdata;
        if (i_cmd.asel == A_CLR) begin
            s_wdata = '0;
        end else if (i_cmd.asel == A_DST) begin
            s_wdata = s_rdata + s_prod;
        end else begin
            case (r_kind)
                K_ADD:   s_wdata = s_rdata + r_amount[7:0];
                K_SET:   s_wdata = r_amount[7:0];
                K_CLEAR: s_wdata = '0;
                K_READ: begin
                    if (!r_in_eof)                    s_wdata = r_in_byte;
                    else if (i_eof_mode == EOF_ZERO)  s_wdata = '0;
                    else if (i_eof_mode == EOF_FF)    s_wdata = 8'hFF;
                    else                              s_wdata = s_rdata;
                end
                default: s_wdata = s_rdata;
            endcase
        end
    end

    tmeu_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
        .i_clk  (i_clk),
        .i_we   (i_cmd.mem_we),
        .i_addr (s_ram_addr),
        .i_wdata(s_wdata),
        .o_rdata(s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_clr   <= '0;
            r_fault <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.load)     r_fault <= 1'b0;
            if (i_cmd.fault_set) r_fault <= 1'b1;
            if (i_cmd.ptr_move) r_ptr <= s_move[AW-1:0];
            if (i_cmd.ptr_scan) r_ptr <= r_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_amount  <= i_amount;
            r_factor  <= i_factor;
            r_offs    <= i_cell_offset;
            r_in_byte <= i_in_byte;
            r_in_eof  <= i_in_eof;
            r_jtaken  <= 1'b0;
            r_put     <= 1'b0;
            r_obyte   <= '0;
        end
        if (i_cmd.cap_src) r_src <= s_rdata;
        if (i_cmd.finish) begin
            if (r_kind == K_JZ)  r_jtaken <= (s_rdata == 8'd0);
            if (r_kind == K_JNZ) r_jtaken <= (s_rdata != 8'd0);
            if (r_kind == K_PUT && r_amount > 0) begin
                r_put   <= 1'b1;
                r_obyte <= s_rdata;
            end
        end
        if (i_cmd.scan_init) r_scan <= r_ptr;
        if (i_cmd.scan_step) r_scan <= s_scan_nx[AW-1:0];
    end

    assign o_sts.clr_done  = (r_clr == AW'(TAPE_DEPTH - 1));
    assign o_sts.kind      = t_kind'(r_kind);
    assign o_sts.addr_ok   = (s_addr >= 0) && (s_addr < DEPTH_S);
    assign o_sts.dst_ok    = (s_dst >= 0) && (s_dst < DEPTH_S);
    assign o_sts.move_ok   = (s_move >= 0) && (s_move < DEPTH_S);
    assign o_sts.rd_zero   = (s_rdata == 8'd0);
    assign o_sts.scan_last = (s_step == 32'd0) || (s_scan_nx < 0) || (s_scan_nx >= DEPTH_S);

    always_comb begin
        o_pc_delta = 32'sd1;
        if (r_fault)                      o_pc_delta = 32'sd1;
        else if (r_kind == K_END)         o_pc_delta = 32'sd0;
        else if (r_jtaken && r_kind == K_JZ)  o_pc_delta = r_amount + 32'sd1;
        else if (r_jtaken && r_kind == K_JNZ) o_pc_delta = 32'sd1 - r_amount;
    end

    assign o_out_valid   = r_put;
    assign o_out_byte    = r_obyte;
    assign o_out_count   = r_put ? r_amount[30:0] : 31'd0;
    assign o_pointer_now = 15'(r_ptr);
    assign o_done_res    = (r_kind == K_END);
    assign o_fault       = r_fault;

    a_ptr_in_tape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ptr_move |-> o_sts.move_ok)
        else $error("pointer moved off tape");
    a_no_write_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fault_set |-> !i_cmd.mem_we)
        else $error("write on faulting word");
endmodule
`default_nettype wire

>>> rtl/tape_machine_execute_unit.sv
// Tape machine execute unit top level: controller plus datapath.
// Depends on tmeu_pkg, tmeu_if, tmeu_ctrl, tmeu_dp, tmeu_ram.
//
// Usage: one decoded instruction word enters on in_ch (valid/ready), one
// result word leaves on out_ch. cfg_ch writes eof_mode while the unit is idle:
// a rule for the user, which the unit itself does not enforce. Move and end
// go straight to the result; add/set/read/clear/put/jumps read one cell;
// mulcopy the source, then the destination cell; scans test one cell at a time.
// All steps are set by the single port of the tape RAM (one access per cycle,
// registered read). One word is in flight at a time; the next is taken the
// cycle after the result is accepted. Reset: pointer and eof_mode go to zero,
// and the tape is swept clear cell by cell, during which no input is taken.
// A stalled receiver holds the result; the unit waits and takes no new input.
`default_nettype none
module tape_machine_execute_unit #(
    parameter int TAPE_DEPTH = 32768
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    tmeu_in_if.sink    in_ch,
    tmeu_out_if.source out_ch,
    tmeu_cfg_if.sink   cfg_ch
);
    import tmeu_pkg::*;

    t_cmd       s_cmd;
    t_sts       s_sts;
    logic [1:0] r_eof_mode;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_mode <= EOF_KEEP;
        end else if (cfg_ch.valid) begin
            r_eof_mode <= cfg_ch.eof_mode;
        end
    end

    tmeu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    tmeu_dp #(.TAPE_DEPTH(TAPE_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .i_kind       (in_ch.kind),
        .i_amount     (in_ch.amount),
        .i_factor     (in_ch.factor),
        .i_cell_offset(in_ch.cell_offset),
        .i_in_byte    (in_ch.in_byte),
        .i_in_eof     (in_ch.in_eof),
        .i_eof_mode   (r_eof_mode),
        .o_out_valid  (out_ch.out_valid),
        .o_out_byte   (out_ch.out_byte),
        .o_out_count  (out_ch.out_count),
        .o_pc_delta   (out_ch.pc_delta),
        .o_pointer_now(out_ch.pointer_now),
        .o_done_res   (out_ch.done_res),
        .o_fault      (out_ch.fault)
    );
endmodule
`default_nettype wire

>>> tb/tb_tape_machine_execute_unit.sv
// Testbench for tape_machine_execute_unit: directed and random instruction words
// checked against an in-bench tape model. Depends on tmeu_pkg, tmeu_if and tape_machine_execute_unit.
`default_nettype none
module tb_tape_machine_execute_unit;
    import tmeu_pkg::*;

    localparam int DEPTH = 32768;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic [30:0] out_count;
        logic [31:0] pc_delta;
        logic [14:0] pointer_now;
        logic        done_res;
        logic        fault;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tmeu_in_if  in_ch();
    tmeu_out_if out_ch();
    tmeu_cfg_if cfg_ch();

    tape_machine_execute_unit #(.TAPE_DEPTH(DEPTH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    initial forever #2 i_clk = ~i_clk;

    logic [7:0]  tape_img [DEPTH];
    int          ptr_img;
    logic [1:0]  eof_img;
    t_result     expected_q[$];
    int          mismatches = 0;
    int          idle_pct = 16;
    int          quiet_cycles = 0;

    initial begin
        in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.amount = '0; in_ch.factor = '0;
        in_ch.cell_offset = '0; in_ch.in_byte = '0; in_ch.in_eof = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.eof_mode = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < DEPTH; i++) tape_img[i] = 8'd0;
        ptr_img = 0;
        eof_img = EOF_KEEP;
    end

    function automatic bit on_tape(longint a);
        return a >= 0 && a < DEPTH;
    endfunction

    function automatic t_result execute_word(logic [3:0] kind, logic [31:0] amt,
                                             logic [15:0] fac, logic [15:0] offs,
                                             logic [7:0] ib, logic ie);
        t_result r;
        longint amount, addr, dst, a, step;
        bit found;
        r = '0;
        r.pc_delta = 32'd1;
        amount = longint'($signed(amt));
        addr = longint'(ptr_img) + longint'($signed(offs));
        case (kind)
            K_ADD, K_SET, K_READ, K_CLEAR, K_PUT: begin
                if (!on_tape(addr)) r.fault = 1'b1;
                else if (kind == K_ADD) tape_img[addr] = tape_img[addr] + amt[7:0];
                else if (kind == K_SET) tape_img[addr] = amt[7:0];
                else if (kind == K_CLEAR) tape_img[addr] = 8'd0;
                else if (kind == K_READ) begin
                    if (!ie) tape_img[addr] = ib;
                    else if (eof_img == EOF_ZERO) tape_img[addr] = 8'd0;
                    else if (eof_img == EOF_FF) tape_img[addr] = 8'd255;
                end else if (amount > 0) begin
                    r.out_valid = 1'b1;
                    r.out_byte = tape_img[addr];
                    r.out_count = amt[30:0];
                end
            end
            K_MOVE: begin
                if (!on_tape(ptr_img + amount)) r.fault = 1'b1;
                else ptr_img = int'(ptr_img + amount);
            end
            K_JZ: if (tape_img[ptr_img] == 0) r.pc_delta = amt + 32'd1;
            K_JNZ: if (tape_img[ptr_img] != 0) r.pc_delta = 32'd1 - amt;
            K_MULCOPY: begin
                dst = addr + amount;
                if (!on_tape(addr) || !on_tape(dst)) r.fault = 1'b1;
                else tape_img[dst] = tape_img[dst] + 8'(tape_img[addr] * fac);
            end
            K_SCANR, K_SCANL: begin
                step = longint'({32'd0, amt});
                a = ptr_img;
                found = 0;
                forever begin
                    if (tape_img[a] == 0) begin found = 1; break; end
                    if (step == 0) break;
                    a = (kind == K_SCANR) ? a + step : a - step;
                    if (!on_tape(a)) break;
                end
                if (found) ptr_img = int'(a);
                else r.fault = 1'b1;
            end
            K_END: begin
                r.done_res = 1'b1;
                r.pc_delta = 32'd0;
            end
            default: ;
        endcase
        if (r.fault) r.pc_delta = 32'd1;
        r.pointer_now = ptr_img[14:0];
        return r;
    endfunction

    // source side: one word per call, random idle before it
    task automatic send_word(logic [3:0] kind, logic [31:0] amt, logic [15:0] fac,
                             logic [15:0] offs, logic [7:0] ib, logic ie);
        t_result exp_w;
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind; in_ch.amount <= amt; in_ch.factor <= fac;
        in_ch.cell_offset <= offs; in_ch.in_byte <= ib; in_ch.in_eof <= ie;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        exp_w = execute_word(kind, amt, fac, offs, ib, ie);
        expected_q = {expected_q, exp_w};
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_eof_mode(logic [1:0] m);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.eof_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        eof_img = m;
    endtask

    // sink side
    always @(posedge i_clk) begin
        if (i_rst_n) out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_result act, exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            act = {out_ch.out_valid, out_ch.out_byte, out_ch.out_count, out_ch.pc_delta,
                   out_ch.pointer_now, out_ch.done_res, out_ch.fault};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", act);
            end else begin
                exp_r = expected_q.pop_front();
                if (act !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp v%0b b%h c%0d pc%h p%0d d%0b f%0b / act v%0b b%h c%0d pc%h p%0d d%0b f%0b",
                                 exp_r.out_valid, exp_r.out_byte, exp_r.out_count,
                                 exp_r.pc_delta, exp_r.pointer_now, exp_r.done_res,
                                 exp_r.fault, act.out_valid, act.out_byte, act.out_count,
                                 act.pc_delta, act.pointer_now, act.done_res, act.fault);
                end
            end
        end
    end

    // watchdog on cycles with no word accepted; allows for the clear sweep
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_word(K_ADD, 32'd255, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_ADD, 32'hFFFF_FF02, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_SET, 32'h7FFF_FFFF, 16'd0, 16'd1, 8'd0, 1'b0);
        send_word(K_PUT, 32'h7FFF_FFFF, 16'd0, 16'd1, 8'd0, 1'b0);
        send_word(K_PUT, 32'h8000_0000, 16'd0, 16'd1, 8'd0, 1'b0);
        send_word(K_PUT, 32'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_ADD, 32'd1, 16'd0, 16'hFFFF, 8'd0, 1'b0);
        send_word(K_SET, 32'd1, 16'd0, 16'h7FFF, 8'd0, 1'b0);
        send_word(K_MOVE, 32'd32767, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_MOVE, 32'd1, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_MOVE, 32'h8000_0000, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_MOVE, 32'hFFFF_8001, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_JZ, 32'h7FFF_FFFF, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_JNZ, 32'h8000_0000, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_READ, 32'd0, 16'd0, 16'd2, 8'hA5, 1'b0);
        send_word(K_READ, 32'd0, 16'd0, 16'd2, 8'hFF, 1'b1);
        send_word(K_MULCOPY, 32'd3, 16'h8000, 16'd1, 8'd0, 1'b0);
        send_word(K_MULCOPY, 32'hFFFF_FFFF, 16'h7FFF, 16'd0, 8'd0, 1'b0);
        send_word(K_MULCOPY, 32'h7FFF_FFFF, 16'd3, 16'd1, 8'd0, 1'b0);
        send_word(K_CLEAR, 32'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_SCANR, 32'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_SCANL, 32'hFFFF_FFFF, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(K_END, 32'd5, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(4'd12, 32'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        send_word(4'd15, 32'd0, 16'd0, 16'd0, 8'd0, 1'b0);
    endtask

    task automatic test_eof_modes();
        for (int m = 0; m < 4; m++) begin
            write_eof_mode(2'(m));
            send_word(K_SET, 32'd7, 16'd0, 16'd0, 8'd0, 1'b0);
            send_word(K_READ, 32'd0, 16'd0, 16'd0, 8'($urandom), 1'b1);
            send_word(K_PUT, 32'd1, 16'd0, 16'd0, 8'd0, 1'b0);
        end
    endtask

    // random programs kept near a short window so scans walk a few cells
    task automatic test_random(int n);
        logic [3:0]  kind;
        logic [31:0] amt;
        logic [15:0] offs;
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) idle_pct = 0;
            if (i == n / 2) idle_pct = 16;
            if (i % 150 == 149) write_eof_mode(2'($urandom_range(3)));
            kind = 4'($urandom_range(15));
            if ($urandom_range(9) < 8 && kind > 4'd11) kind = 4'($urandom_range(11));
            offs = 16'($signed($urandom_range(8)) - 4);
            amt = 32'($signed($urandom_range(16)) - 8);
            if ($urandom_range(9) == 0) begin
                offs = 16'($urandom);
                amt = $urandom;
            end
            if (kind == K_SCANR || kind == K_SCANL) begin
                amt = $urandom_range(3);
                if ($urandom_range(15) == 0) amt = $urandom;
            end
            send_word(kind, amt, 16'($urandom), offs, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_eof_modes();
        test_random(430);
        drain();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
